### rtl/krrt_pkg.sv
package krrt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH  = 6;
   localparam int REPORT_SLOTS = 6;
   localparam int SLOT_LIMIT   = (TABLE_DEPTH < REPORT_SLOTS) ? TABLE_DEPTH : REPORT_SLOTS;
   localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Field widths.
   localparam int FUNC_W = 2;
   localparam int KEY_W  = 8;
   localparam int TIME_W = 64;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_FIELDS_W = KEY_W + 2 * TIME_W + 1;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 + REPORT_SLOTS * KEY_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Command queue between the decoder and the table engine (power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   // Request function codes as they arrive on the bus.
   localparam logic [FUNC_W-1:0] FUNC_PRESS       = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PRESS_TIMED = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE     = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_POLL        = 2'd3;

   // Decoded operations handed to the table engine.
   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_SCAN    = 2'd2;
   localparam logic [1:0] OP_SKIP    = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      logic              timed;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] now;
   } krrt_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] held_count;
      logic             report_pending;
      logic             accepted;
      logic             report_sent;
   } krrt_status_type;

endpackage

### rtl/key_rollover_report_table_unit.sv
// Channel   Direction  Payload
// req_      in         tuser: func; tdata: key_code, release_deadline, now_us, host_ready
// rsp_      out        tdata: accepted, report_sent, slot_zero .. slot_five
//
// A press, release or idle poll is answered in the cycle after it leaves the command queue.
// A poll with the host ready sweeps the table one entry per cycle, then passes through
// the emit state before it is answered; no new request is taken until then, and a poll
// on a full table of six is the slowest request.
// Reset is synchronous and clears the count, the pending flag and all handshake state.
// Up to two requests queue while the engine works or a result waits to be taken.
module key_rollover_report_table_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // func
   input  logic [krrt_pkg::FUNC_W-1:0]           req_tuser,
   // key_code, release_deadline, now_us, host_ready, zero fill
   input  logic [krrt_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // accepted, report_sent, slot_zero .. slot_five, zero fill
   output logic [krrt_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import krrt_pkg::*;

   krrt_cmd_type      dec_cmd;
   krrt_cmd_type      q_cmd;
   logic              q_valid;
   logic              q_ready;
   logic [QLVL_W-1:0] q_level;
   krrt_status_type   status;
   logic [REPORT_SLOTS-1:0][KEY_W-1:0] slots;

   // Request decode.
   krrt_front u_front (
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (dec_cmd)
   );

   // Queue between decode and the table engine.
   krrt_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_cmd   (dec_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd),
      .level      (q_level)
   );

   // Table engine with its result register.
   krrt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_slots (slots),
      .status    (status)
   );

   // Pack the result, first field in the lowest bit.
   assign rsp_tdata = RSP_DATA_W'({slots, status.report_sent, status.accepted});

`ifndef SYNTHESIS
   // The table never holds more entries than it has rows.
   assert property (@(posedge clock) disable iff (reset)
      status.held_count <= CNT_W'(TABLE_DEPTH))
      else $error("held count exceeds table depth");

   // A result is either a press or release outcome or a report, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(status.accepted && status.report_sent))
      else $error("result marked accepted and report sent");

   // Requests are refused only when the queue is full.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (q_level == QLVL_W'(QUEUE_DEPTH)))
      else $error("request refused with queue space free");

   // The cycle after reset the table is empty and nothing is pending.
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (status.held_count == '0) && !status.report_pending)
      else $error("table state not cleared by reset");
`endif

endmodule

### rtl/krrt_front.sv
module krrt_front (
   input  logic [krrt_pkg::FUNC_W-1:0]     req_tuser,
   input  logic [krrt_pkg::REQ_DATA_W-1:0] req_tdata,
   output krrt_pkg::krrt_cmd_type          cmd
);
   import krrt_pkg::*;

   logic [KEY_W-1:0]  key;
   logic [TIME_W-1:0] deadline;
   logic [TIME_W-1:0] now;
   logic              host_ready;

   // Unpack the request payload.
   assign key        = req_tdata[KEY_W-1:0];
   assign deadline   = req_tdata[KEY_W +: TIME_W];
   assign now        = req_tdata[KEY_W + TIME_W +: TIME_W];
   assign host_ready = req_tdata[KEY_W + 2 * TIME_W];

   // Classify the request into an engine operation.
   always_comb begin
      cmd          = '0;
      cmd.key      = key;
      cmd.now      = now;
      unique case (req_tuser)
         FUNC_PRESS: begin
            cmd.op = OP_PRESS;
         end
         FUNC_PRESS_TIMED: begin
            cmd.op       = OP_PRESS;
            cmd.timed    = 1'b1;
            cmd.deadline = deadline;
         end
         FUNC_RELEASE: begin
            cmd.op = OP_RELEASE;
         end
         FUNC_POLL: begin
            // A poll the host cannot take leaves the table untouched.
            cmd.op = host_ready ? OP_SCAN : OP_SKIP;
         end
         default: begin
            cmd.op = OP_SKIP;
         end
      endcase
   end

endmodule

### rtl/krrt_cmd_queue.sv
module krrt_cmd_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   output logic                          push_ready,
   input  krrt_pkg::krrt_cmd_type        push_cmd,
   output logic                          pop_valid,
   input  logic                          pop_ready,
   output krrt_pkg::krrt_cmd_type        pop_cmd,
   output logic [krrt_pkg::QLVL_W-1:0]   level
);
   import krrt_pkg::*;

   krrt_cmd_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QLVL_W-1:0] level_ff;
   logic              push;
   logic              pop;

   assign push_ready = (level_ff != QLVL_W'(QUEUE_DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign level      = level_ff;

   // Storage; pointers wrap naturally since the depth is a power of two.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + QLVL_W'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - QLVL_W'(1);
         end
      end
   end

endmodule

### rtl/krrt_back.sv
module krrt_back (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         cmd_valid,
   output logic                                         cmd_ready,
   input  krrt_pkg::krrt_cmd_type                       cmd,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic [krrt_pkg::REPORT_SLOTS-1:0][krrt_pkg::KEY_W-1:0] rsp_slots,
   output krrt_pkg::krrt_status_type                    status
);
   import krrt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // Key table, held in flops; entries at or above the count are dead.
   logic [KEY_W-1:0]  key_ff      [TABLE_DEPTH];
   logic [KEY_W-1:0]  key_in      [TABLE_DEPTH];
   logic              timed_ff    [TABLE_DEPTH];
   logic              timed_in    [TABLE_DEPTH];
   logic [TIME_W-1:0] dl_ff       [TABLE_DEPTH];
   logic [TIME_W-1:0] dl_in       [TABLE_DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              pending_ff;
   logic              pending_in;

   // Sequencer for the expiry sweep.
   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [CNT_W-1:0]  rd_ff;
   logic [CNT_W-1:0]  rd_in;
   logic [CNT_W-1:0]  wr_ff;
   logic [CNT_W-1:0]  wr_in;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] now_in;

   // Result register.
   logic              rsp_valid_ff;
   logic              acc_ff;
   logic              acc_in;
   logic              sent_ff;
   logic              sent_in;
   logic [REPORT_SLOTS-1:0][KEY_W-1:0] slot_ff;
   logic [REPORT_SLOTS-1:0][KEY_W-1:0] slot_in;
   logic              rsp_load;
   logic              out_free;

   logic [TABLE_DEPTH-1:0] hit;
   logic              found;
   logic [IDX_W-1:0]  at;
   logic [IDX_W-1:0]  ridx;
   logic [IDX_W-1:0]  widx;
   logic [IDX_W-1:0]  cidx;
   logic              expired;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;
   assign ridx      = rd_ff[IDX_W-1:0];
   assign widx      = wr_ff[IDX_W-1:0];
   assign cidx      = count_ff[IDX_W-1:0];
   assign expired   = timed_ff[ridx] && (now_ff > dl_ff[ridx]);

   // Look up the request key among the live entries.
   always_comb begin
      at = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit[i] = (CNT_W'(i) < count_ff) && (key_ff[i] == cmd.key);
      end
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (hit[i]) begin
            at = IDX_W'(i);
         end
      end
   end
   assign found = |hit;

   // Table update and result formation.
   always_comb begin
      key_in     = key_ff;
      timed_in   = timed_ff;
      dl_in      = dl_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      state_in   = state_ff;
      rd_in      = rd_ff;
      wr_in      = wr_ff;
      now_in     = now_ff;
      rsp_load   = 1'b0;
      acc_in     = 1'b0;
      sent_in    = 1'b0;
      slot_in    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               unique case (cmd.op)
                  OP_PRESS: begin
                     rsp_load = 1'b1;
                     if (!found && (count_ff < CNT_W'(TABLE_DEPTH))) begin
                        key_in[cidx]   = cmd.key;
                        timed_in[cidx] = cmd.timed;
                        dl_in[cidx]    = cmd.deadline;
                        count_in       = count_ff + CNT_W'(1);
                        pending_in     = 1'b1;
                        acc_in         = 1'b1;
                     end
                  end
                  OP_RELEASE: begin
                     rsp_load = 1'b1;
                     if (found) begin
                        // Close the gap: later entries move up one place.
                        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                           if ((IDX_W'(i) >= at) && (CNT_W'(i + 1) < count_ff)) begin
                              key_in[i]   = key_ff[i + 1];
                              timed_in[i] = timed_ff[i + 1];
                              dl_in[i]    = dl_ff[i + 1];
                           end
                        end
                        count_in   = count_ff - CNT_W'(1);
                        pending_in = 1'b1;
                        acc_in     = 1'b1;
                     end
                  end
                  OP_SCAN: begin
                     rd_in    = '0;
                     wr_in    = '0;
                     now_in   = cmd.now;
                     state_in = ST_SCAN;
                  end
                  OP_SKIP: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // One entry per cycle: keep it by copying down, or drop it.
            if (rd_ff < count_ff) begin
               if (!expired) begin
                  key_in[widx]   = key_ff[ridx];
                  timed_in[widx] = timed_ff[ridx];
                  dl_in[widx]    = dl_ff[ridx];
                  wr_in          = wr_ff + CNT_W'(1);
               end
               rd_in = rd_ff + CNT_W'(1);
            end else begin
               if (wr_ff != count_ff) begin
                  count_in   = wr_ff;
                  pending_in = 1'b1;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (pending_ff) begin
                  sent_in    = 1'b1;
                  pending_in = 1'b0;
                  for (int i = 0; i < SLOT_LIMIT; i++) begin
                     if (CNT_W'(i) < count_ff) begin
                        slot_in[i] = key_ff[i];
                     end
                  end
                  // Entries past the report width are lost once reported.
                  if (count_ff > CNT_W'(SLOT_LIMIT)) begin
                     count_in = CNT_W'(SLOT_LIMIT);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Table payload and sweep pointers.
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      timed_ff <= timed_in;
      dl_ff    <= dl_in;
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      now_ff   <= now_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   // Result register, drained independently of the table.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         acc_ff  <= acc_in;
         sent_ff <= sent_in;
         slot_ff <= slot_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_slots             = slot_ff;
   assign status.held_count     = count_ff;
   assign status.report_pending = pending_ff;
   assign status.accepted       = acc_ff;
   assign status.report_sent    = sent_ff;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import krrt_pkg::*;

   // One result word as it leaves the block, lowest field in the lowest bits.
   typedef struct packed {
      logic [REPORT_SLOTS-1:0][KEY_W-1:0] slots;
      logic                               report_sent;
      logic                               accepted;
   } key_report_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Local copy of the key table, advanced once per accepted request.
   logic [KEY_W-1:0]  held_key [TABLE_DEPTH];
   logic              held_timed [TABLE_DEPTH];
   logic [TIME_W-1:0] held_deadline [TABLE_DEPTH];
   int                held_total   = 0;
   logic              report_due   = 1'b0;

   key_report_type report_queue [$];
   int          errors        = 0;
   bit          steady_flow   = 1'b0;
   int          stall_request = 0;

   // Stimulus helpers for the random traffic.
   logic [TIME_W-1:0] wall_clock_us = '0;
   logic [KEY_W-1:0]  key_pool [8];

   string slot_label [REPORT_SLOTS] = '{"slot_zero", "slot_one", "slot_two",
                                        "slot_three", "slot_four", "slot_five"};

   key_rollover_report_table_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int idle_cycles();
      if (steady_flow) begin
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [TIME_W-1:0] random_time();
      return {$urandom, $urandom};
   endfunction

   function automatic int find_held(logic [KEY_W-1:0] key);
      for (int i = 0; i < held_total; i++) begin
         if (held_key[i] == key) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Apply one request to the local table and return the result it should produce.
   function automatic key_report_type apply_key_request(logic [FUNC_W-1:0] func,
                                                        logic [KEY_W-1:0] key,
                                                        logic [TIME_W-1:0] deadline,
                                                        logic [TIME_W-1:0] now,
                                                        logic ready);
      key_report_type result;
      int          at;
      int          kept;
      result = '0;
      case (func)
         FUNC_PRESS, FUNC_PRESS_TIMED: begin
            at = find_held(key);
            if (at < 0 && held_total < TABLE_DEPTH) begin
               held_key[held_total]      = key;
               held_timed[held_total]    = (func == FUNC_PRESS_TIMED);
               held_deadline[held_total] = (func == FUNC_PRESS_TIMED) ? deadline : '0;
               held_total++;
               report_due      = 1'b1;
               result.accepted = 1'b1;
            end
         end
         FUNC_RELEASE: begin
            at = find_held(key);
            if (at >= 0) begin
               for (int i = at; i + 1 < held_total; i++) begin
                  held_key[i]      = held_key[i + 1];
                  held_timed[i]    = held_timed[i + 1];
                  held_deadline[i] = held_deadline[i + 1];
               end
               held_total--;
               report_due      = 1'b1;
               result.accepted = 1'b1;
            end
         end
         default: begin
            if (ready) begin
               // Expired entries are dropped; the rest keep their order.
               kept = 0;
               for (int i = 0; i < held_total; i++) begin
                  if (!(held_timed[i] && now > held_deadline[i])) begin
                     held_key[kept]      = held_key[i];
                     held_timed[kept]    = held_timed[i];
                     held_deadline[kept] = held_deadline[i];
                     kept++;
                  end
               end
               if (kept != held_total) begin
                  held_total = kept;
                  report_due = 1'b1;
               end
               if (report_due) begin
                  if (held_total > REPORT_SLOTS) begin
                     held_total = REPORT_SLOTS;
                  end
                  for (int i = 0; i < held_total; i++) begin
                     result.slots[i] = held_key[i];
                  end
                  result.report_sent = 1'b1;
                  report_due         = 1'b0;
               end
            end
         end
      endcase
      return result;
   endfunction

   // Offer one request after a random gap and record its expected result once taken.
   task automatic send_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                               logic [TIME_W-1:0] deadline, logic [TIME_W-1:0] now,
                               logic ready);
      int                    gap;
      logic [REQ_DATA_W-1:0] word;
      key_report_type        expected;
      gap  = idle_cycles();
      word = '0;
      word[KEY_W-1:0]                      = key;
      word[KEY_W +: TIME_W]                = deadline;
      word[KEY_W + TIME_W +: TIME_W]       = now;
      word[KEY_W + 2 * TIME_W]             = ready;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      expected     = apply_key_request(func, key, deadline, now, ready);
      report_queue = {report_queue, expected};
   endtask

   // One random request: mostly presses and releases on a small key pool with
   // deadlines near a running clock, plus some fully random noise.
   task automatic send_random_request();
      int                pick;
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] now;
      logic              ready;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         func = FUNC_PRESS;
      end else if (pick < 55) begin
         func = FUNC_PRESS_TIMED;
      end else if (pick < 75) begin
         func = FUNC_RELEASE;
      end else begin
         func = FUNC_POLL;
      end
      key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 7)]
                                        : 8'($urandom_range(0, 255));
      if (func == FUNC_RELEASE && held_total > 0 && $urandom_range(0, 1) == 1) begin
         key = held_key[$urandom_range(0, held_total - 1)];
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         deadline = wall_clock_us + 64'($urandom_range(0, 3000));
      end else if (pick < 85) begin
         deadline = wall_clock_us - 64'($urandom_range(0, 50));
      end else begin
         deadline = random_time();
      end
      if (func == FUNC_POLL) begin
         wall_clock_us = wall_clock_us + 64'($urandom_range(0, 400));
         now   = ($urandom_range(0, 19) == 0) ? random_time() : wall_clock_us;
         ready = ($urandom_range(0, 7) != 0);
      end else begin
         now   = random_time();
         ready = 1'($urandom_range(0, 1));
      end
      // Now and then move to a fresh key pool and a fresh point in time.
      if ($urandom_range(0, 199) == 0) begin
         foreach (key_pool[i]) key_pool[i] = 8'($urandom_range(0, 255));
         wall_clock_us = random_time();
      end
      send_request(func, key, deadline, now, ready);
   endtask

   // Result side: random back pressure, with an occasional long hold-off.
   initial begin : result_sink
      int gap;
      @(negedge reset);
      forever begin
         if (stall_request > 0) begin
            gap           = stall_request;
            stall_request = 0;
            rsp_tready   <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            gap = idle_cycles();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Compare each result taken from the block with the oldest expectation.
   always @(posedge clock) begin : check_results
      key_report_type seen;
      key_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[RSP_FIELDS_W-1:0];
         if (report_queue.size() == 0) begin
            $error("result with no request waiting: %h", seen);
            errors++;
         end else begin
            want = report_queue.pop_front();
            if (seen.accepted !== want.accepted) begin
               $error("accepted: expected %0h, actual %0h", want.accepted, seen.accepted);
               errors++;
            end
            if (seen.report_sent !== want.report_sent) begin
               $error("report_sent: expected %0h, actual %0h",
                      want.report_sent, seen.report_sent);
               errors++;
            end
            for (int i = 0; i < REPORT_SLOTS; i++) begin
               if (seen.slots[i] !== want.slots[i]) begin
                  $error("%s: expected %0h, actual %0h", slot_label[i],
                         want.slots[i], seen.slots[i]);
                  errors++;
               end
            end
         end
      end
   end

   // Polls on an empty table and presses up to the table limit.
   task automatic test_press_limits();
      send_request(FUNC_POLL, 8'h00, '0, '0, 1'b1);
      send_request(FUNC_POLL, 8'h00, '1, '1, 1'b0);
      send_request(FUNC_PRESS, 8'h00, '1, '0, 1'b0);
      send_request(FUNC_PRESS, 8'hFF, '0, '1, 1'b1);
      send_request(FUNC_PRESS, 8'hFF, '0, '0, 1'b0);
      send_request(FUNC_PRESS_TIMED, 8'h04, '1, '0, 1'b0);
      send_request(FUNC_PRESS_TIMED, 8'h05, '0, '0, 1'b0);
      send_request(FUNC_PRESS_TIMED, 8'h06, 64'd1000, '0, 1'b0);
      send_request(FUNC_PRESS, 8'h07, '0, '0, 1'b0);
      send_request(FUNC_PRESS, 8'h08, '0, '0, 1'b0);
      send_request(FUNC_POLL, 8'h00, '0, '1, 1'b0);
      send_request(FUNC_POLL, 8'h00, '0, '0, 1'b1);
      send_request(FUNC_POLL, 8'h00, '0, '0, 1'b1);
   endtask

   // A deadline equal to now is kept; one earlier than now is dropped.
   task automatic test_deadline_expiry();
      send_request(FUNC_POLL, 8'h00, '0, 64'd1000, 1'b1);
      send_request(FUNC_POLL, 8'h00, '0, 64'd1001, 1'b1);
      send_request(FUNC_PRESS_TIMED, 8'h2A, 64'd5, '0, 1'b0);
      send_request(FUNC_POLL, 8'h00, '0, '1, 1'b1);
   endtask

   // Releases of absent and middle keys, then a report of an empty table.
   task automatic test_release();
      send_request(FUNC_RELEASE, 8'h99, '0, '0, 1'b0);
      send_request(FUNC_RELEASE, 8'hFF, '0, '0, 1'b0);
      send_request(FUNC_POLL, 8'h00, '0, 64'd1001, 1'b1);
      send_request(FUNC_RELEASE, 8'h00, '0, '0, 1'b0);
      send_request(FUNC_RELEASE, 8'h04, '0, '0, 1'b0);
      send_request(FUNC_RELEASE, 8'h07, '0, '0, 1'b0);
      send_request(FUNC_POLL, 8'h00, '0, 64'd1001, 1'b1);
      send_request(FUNC_RELEASE, 8'h2A, '0, '0, 1'b0);
   endtask

   task automatic test_random_traffic();
      foreach (key_pool[i]) key_pool[i] = 8'($urandom_range(0, 255));
      wall_clock_us = 64'($urandom);
      repeat (1100) send_random_request();
   endtask

   // Back-to-back requests and results with no idle cycles on either side.
   task automatic test_full_throughput();
      steady_flow = 1'b1;
      repeat (120) send_random_request();
      steady_flow = 1'b0;
   endtask

   // The result side holds off long enough for the request side to stall.
   task automatic test_output_stall();
      stall_request = 300;
      steady_flow   = 1'b1;
      repeat (40) send_random_request();
      steady_flow = 1'b0;
      repeat (60) send_random_request();
   endtask

   initial begin : run_tests
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_press_limits();
      test_deadline_expiry();
      test_release();
      test_random_traffic();
      test_full_throughput();
      test_output_stall();
      req_tvalid <= 1'b0;
      while (report_queue.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/krrt_pkg.sv
rtl/krrt_front.sv
rtl/krrt_cmd_queue.sv
rtl/krrt_back.sv
rtl/key_rollover_report_table_unit.sv
tb/sv/tb_top.sv
